/* rtl/mel_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mel_pkg: shared types and constants of the expression lexer
// Character classes, queue entry, result record and the code tables.
// ----------------------------------------------------------------------------
package mel_pkg;

   localparam int LINE_MAX_DEFAULT    = 4096;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int CH_W    = 8;
   localparam int START_W = 12;
   localparam int LEN_W   = 13;

   typedef enum logic [3:0] {
      CLS_SPACE,
      CLS_COMMA,
      CLS_LPAREN,
      CLS_RPAREN,
      CLS_OP,
      CLS_DIGIT,
      CLS_DOT,
      CLS_UNDER,
      CLS_ALPHA,
      CLS_OTHER
   } char_class_type;

   typedef enum logic [1:0] {
      ST_TOKEN,
      ST_BAD_CHAR,
      ST_MULTI_DOT,
      ST_TOO_LONG
   } status_type;

   typedef enum logic [2:0] {
      TK_LPAREN,
      TK_RPAREN,
      TK_OPER,
      TK_CONST,
      TK_FUNC,
      TK_VECTOR,
      TK_MATRIX,
      TK_VAR
   } token_kind_type;

   // one classified request as it travels through the queue
   typedef struct packed {
      logic            eol;
      logic [CH_W-1:0] ch;
      char_class_type  cls;
   } entry_type;

   // one result record
   typedef struct packed {
      status_type         status;
      token_kind_type     token_kind;
      logic [START_W-1:0] start_pos;
      logic [LEN_W-1:0]   token_len;
      logic [CH_W-1:0]    op_char;
      logic               last_of_run;
   } result_type;

endpackage : mel_pkg
`default_nettype wire

/* rtl/mel_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mel_front: request intake and character classification
// Takes requests while the queue has room and tags each with its class.
// ----------------------------------------------------------------------------
module mel_front
   import mel_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire logic            req_kind,
   input  wire logic [CH_W-1:0] req_ch,
   input  wire logic            q_full,
   output logic                 q_push,
   output entry_type            q_entry
);

   localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
   localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
   localparam logic [CH_W-1:0] CH_COMMA  = 8'h2C;
   localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CH_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
   localparam logic [CH_W-1:0] CH_CARET  = 8'h5E;
   localparam logic [CH_W-1:0] CH_DOT    = 8'h2E;
   localparam logic [CH_W-1:0] CH_UNDER  = 8'h5F;
   localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
   localparam logic [CH_W-1:0] CH_LC_A   = 8'h61;
   localparam logic [CH_W-1:0] CH_LC_Z   = 8'h7A;
   localparam logic [CH_W-1:0] CH_UC_A   = 8'h41;
   localparam logic [CH_W-1:0] CH_UC_Z   = 8'h5A;

   char_class_type cls;

   always_comb begin
      // tab through carriage return covers \t \n \v \f \r
      priority if (req_ch == CH_SPACE || (req_ch >= CH_TAB && req_ch <= CH_CR)) begin
         cls = CLS_SPACE;
      end else if (req_ch == CH_COMMA) begin
         cls = CLS_COMMA;
      end else if (req_ch == CH_LPAREN) begin
         cls = CLS_LPAREN;
      end else if (req_ch == CH_RPAREN) begin
         cls = CLS_RPAREN;
      end else if (req_ch == CH_PLUS || req_ch == CH_MINUS || req_ch == CH_STAR ||
                   req_ch == CH_SLASH || req_ch == CH_CARET) begin
         cls = CLS_OP;
      end else if (req_ch >= CH_ZERO && req_ch <= CH_NINE) begin
         cls = CLS_DIGIT;
      end else if (req_ch == CH_DOT) begin
         cls = CLS_DOT;
      end else if (req_ch == CH_UNDER) begin
         cls = CLS_UNDER;
      end else if ((req_ch >= CH_LC_A && req_ch <= CH_LC_Z) ||
                   (req_ch >= CH_UC_A && req_ch <= CH_UC_Z)) begin
         cls = CLS_ALPHA;
      end else begin
         cls = CLS_OTHER;
      end
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign q_entry   = '{eol: req_kind, ch: req_ch, cls: cls};

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("mel_front: push into a full queue");
`endif

endmodule : mel_front
`default_nettype wire

/* rtl/mel_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mel_fifo: request queue between front and back
// Small register queue; head entry is visible while not empty.
// ----------------------------------------------------------------------------
module mel_fifo
   import mel_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   output logic           full,
   input  wire logic      pop,
   output entry_type      head,
   output logic           not_empty
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   entry_type        slot_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff;
   logic [IDX_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            slot_ff[wr_ptr_ff] <= push_entry;
            wr_ptr_ff <= (wr_ptr_ff == IDX_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == IDX_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("mel_fifo: count beyond depth");
`endif

endmodule : mel_fifo
`default_nettype wire

/* rtl/mel_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mel_back: lexer state machine and result register
// Pops one request a cycle unless stalled, updates the lexer and emits up to two results.
// ----------------------------------------------------------------------------
module mel_back
   import mel_pkg::*;
#(
   parameter int LINE_MAX = LINE_MAX_DEFAULT
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire entry_type q_head,
   input  wire logic      q_not_empty,
   output logic           q_pop,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output result_type     rsp_res
);

   localparam int POS_W = $clog2(LINE_MAX + 1);
   localparam logic [POS_W-1:0] LINE_LAST = POS_W'(LINE_MAX);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_NUM,
      MODE_NAME,
      MODE_ERR
   } mode_type;

   mode_type         mode_ff,  mode_in;
   logic [POS_W-1:0] pos_ff,   pos_in;
   logic [POS_W-1:0] tstart_ff, tstart_in;
   logic             seen_dot_ff, seen_dot_in;
   logic             seen_under_ff, seen_under_in;
   logic             out_vld_ff;
   result_type       out_res_ff;
   logic             pend_vld_ff;
   result_type       pend_res_ff;

   logic [POS_W-1:0]         len_raw;
   logic [POS_W+LEN_W-1:0]   pos_ext;
   logic [POS_W+LEN_W-1:0]   tstart_ext;
   logic [POS_W+LEN_W-1:0]   len_ext;
   logic [START_W-1:0]       cur_start;
   logic [START_W-1:0]       tok_start;
   logic [LEN_W-1:0]         tok_len;
   token_kind_type           name_kind;

   result_type first_res, idle_res, r0, r1;
   logic       first_vld, idle_vld, run_idle, any_res, two_res;
   logic       out_free, go;

   function automatic result_type mk_res(status_type st, token_kind_type tk,
                                         logic [START_W-1:0] sp,
                                         logic [LEN_W-1:0] len,
                                         logic [CH_W-1:0] op);
      result_type r;
      r.status      = st;
      r.token_kind  = tk;
      r.start_pos   = sp;
      r.token_len   = len;
      r.op_char     = op;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   // every token length ends at the current position
   assign len_raw    = pos_ff - tstart_ff;
   assign pos_ext    = {{LEN_W{1'b0}}, pos_ff};
   assign tstart_ext = {{LEN_W{1'b0}}, tstart_ff};
   assign len_ext    = {{LEN_W{1'b0}}, len_raw};
   assign cur_start  = pos_ext[START_W-1:0];
   assign tok_start  = tstart_ext[START_W-1:0];
   assign tok_len    = len_ext[LEN_W-1:0];

   always_comb begin
      priority if (seen_dot_ff) begin
         name_kind = TK_VECTOR;
      end else if (seen_under_ff) begin
         name_kind = TK_MATRIX;
      end else begin
         name_kind = TK_VAR;
      end
   end

   always_comb begin
      mode_in       = mode_ff;
      pos_in        = pos_ff;
      tstart_in     = tstart_ff;
      seen_dot_in   = seen_dot_ff;
      seen_under_in = seen_under_ff;
      first_res     = '0;
      first_vld     = 1'b0;
      idle_res      = '0;
      idle_vld      = 1'b0;
      run_idle      = 1'b0;

      if (q_head.eol) begin
         if (mode_ff == MODE_NUM) begin
            first_res = mk_res(ST_TOKEN, TK_CONST, tok_start, tok_len, '0);
            first_vld = 1'b1;
         end else if (mode_ff == MODE_NAME) begin
            first_res = mk_res(ST_TOKEN, name_kind, tok_start, tok_len, '0);
            first_vld = 1'b1;
         end
         mode_in       = MODE_IDLE;
         pos_in        = '0;
         tstart_in     = '0;
         seen_dot_in   = 1'b0;
         seen_under_in = 1'b0;
      end else if (mode_ff == MODE_ERR) begin
         // dropped until end of line
      end else if (pos_ff == LINE_LAST) begin
         first_res = mk_res(ST_TOO_LONG, TK_LPAREN, '0, '0, '0);
         first_vld = 1'b1;
         mode_in   = MODE_ERR;
      end else begin
         pos_in = pos_ff + 1'b1;
         unique case (mode_ff)
            MODE_NUM: begin
               if (q_head.cls == CLS_DIGIT) begin
                  // number grows
               end else if (q_head.cls == CLS_DOT) begin
                  if (seen_dot_ff) begin
                     first_res = mk_res(ST_MULTI_DOT, TK_LPAREN, cur_start, LEN_W'(1), '0);
                     first_vld = 1'b1;
                     mode_in   = MODE_ERR;
                  end else begin
                     seen_dot_in = 1'b1;
                  end
               end else begin
                  first_res = mk_res(ST_TOKEN, TK_CONST, tok_start, tok_len, '0);
                  first_vld = 1'b1;
                  run_idle  = 1'b1;
               end
            end
            MODE_NAME: begin
               if (q_head.cls == CLS_LPAREN) begin
                  first_res = mk_res(ST_TOKEN, TK_FUNC, tok_start, tok_len, '0);
                  first_vld = 1'b1;
                  run_idle  = 1'b1;
               end else if (q_head.cls == CLS_OP || q_head.cls == CLS_COMMA ||
                            q_head.cls == CLS_RPAREN) begin
                  first_res = mk_res(ST_TOKEN, name_kind, tok_start, tok_len, '0);
                  first_vld = 1'b1;
                  run_idle  = 1'b1;
               end else begin
                  if (q_head.cls == CLS_DOT) seen_dot_in = 1'b1;
                  if (q_head.cls == CLS_UNDER) seen_under_in = 1'b1;
               end
            end
            MODE_IDLE: begin
               run_idle = 1'b1;
            end
            MODE_ERR: begin
               // handled above
            end
         endcase

         if (run_idle) begin
            mode_in = MODE_IDLE;
            unique case (q_head.cls)
               CLS_SPACE, CLS_COMMA: begin
               end
               CLS_LPAREN: begin
                  idle_res = mk_res(ST_TOKEN, TK_LPAREN, cur_start, LEN_W'(1), '0);
                  idle_vld = 1'b1;
               end
               CLS_RPAREN: begin
                  idle_res = mk_res(ST_TOKEN, TK_RPAREN, cur_start, LEN_W'(1), '0);
                  idle_vld = 1'b1;
               end
               CLS_OP: begin
                  idle_res = mk_res(ST_TOKEN, TK_OPER, cur_start, LEN_W'(1), q_head.ch);
                  idle_vld = 1'b1;
               end
               CLS_DIGIT, CLS_ALPHA: begin
                  mode_in       = (q_head.cls == CLS_DIGIT) ? MODE_NUM : MODE_NAME;
                  tstart_in     = pos_ff;
                  seen_dot_in   = 1'b0;
                  seen_under_in = 1'b0;
               end
               CLS_DOT, CLS_UNDER, CLS_OTHER: begin
                  idle_res = mk_res(ST_BAD_CHAR, TK_LPAREN, cur_start, LEN_W'(1), '0);
                  idle_vld = 1'b1;
                  mode_in  = MODE_ERR;
               end
            endcase
         end
      end
   end

   // pack results: flushed token first, then the idle-mode token
   always_comb begin
      any_res = first_vld || idle_vld;
      two_res = first_vld && idle_vld;
      r0      = first_vld ? first_res : idle_res;
      r1      = idle_res;
      r0.last_of_run = !two_res;
      r1.last_of_run = 1'b1;
   end

   assign out_free = !out_vld_ff || !rsp_stall;
   assign go       = q_not_empty && !pend_vld_ff && (out_free || !any_res);
   assign q_pop    = go;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         pos_ff        <= '0;
         tstart_ff     <= '0;
         seen_dot_ff   <= 1'b0;
         seen_under_ff <= 1'b0;
         out_vld_ff    <= 1'b0;
         pend_vld_ff   <= 1'b0;
      end else if (pend_vld_ff) begin
         if (out_free) begin
            out_res_ff  <= pend_res_ff;
            out_vld_ff  <= 1'b1;
            pend_vld_ff <= 1'b0;
         end
      end else if (go) begin
         mode_ff       <= mode_in;
         pos_ff        <= pos_in;
         tstart_ff     <= tstart_in;
         seen_dot_ff   <= seen_dot_in;
         seen_under_ff <= seen_under_in;
         if (any_res) begin
            out_res_ff  <= r0;
            out_vld_ff  <= 1'b1;
            pend_res_ff <= r1;
            pend_vld_ff <= two_res;
         end else if (out_free) begin
            out_vld_ff <= 1'b0;
         end
      end else if (out_free) begin
         out_vld_ff <= 1'b0;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_res   = out_res_ff;

`ifndef SYNTHESIS
   a_pend_behind_out: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> out_vld_ff)
      else $error("mel_back: second result waiting without a first");
   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> !out_res_ff.last_of_run)
      else $error("mel_back: first of two results marked last");
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LINE_LAST)
      else $error("mel_back: position beyond line limit");
   a_start_before_pos: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_NUM || mode_ff == MODE_NAME) |-> tstart_ff < pos_ff)
      else $error("mel_back: token start not behind position");
   a_no_pop_while_pending: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> !q_pop)
      else $error("mel_back: request taken while a result is pending");
`endif

endmodule : mel_back
`default_nettype wire

/* rtl/math_expression_lexer_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// math_expression_lexer_core: streaming lexer for one expression line
// Front classifies requests into a small queue; back runs the lexer.
// ----------------------------------------------------------------------------
// Each request carries one character of a line or an end-of-line mark; the
// block answers with token records (parentheses, operators, constants, and
// names sorted into function call, vector access, matrix access or variable)
// or error records, with last_of_run set on the final record of each
// request. A request is taken every cycle while the queue (default depth
// four) has room; the lexer consumes one request per cycle, the sustained
// rate, unless a second record is pending or the result side stalls. A
// request yielding two records (a name or number closed by a parenthesis or
// operator, or a number cut by a bad byte) holds the lexer until its second
// record moves into the result register. Records pass the queue, lexer and
// result register in turn. After an error every character is dropped until
// the end-of-line request, which also flushes a pending name or number.
// ----------------------------------------------------------------------------
module math_expression_lexer_core
   import mel_pkg::*;
#(
   parameter int LINE_MAX    = LINE_MAX_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_kind,
   input  wire logic [CH_W-1:0]    req_ch,
   // result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [2:0]              rsp_token_kind,
   output logic [START_W-1:0]      rsp_start_pos,
   output logic [LEN_W-1:0]        rsp_token_len,
   output logic [CH_W-1:0]         rsp_op_char,
   output logic                    rsp_last_of_run
);

   // queue handshake between front and back
   logic       q_full;
   logic       q_push;
   entry_type  q_entry;
   logic       q_pop;
   entry_type  q_head;
   logic       q_not_empty;
   result_type rsp_res;

   mel_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .req_ch    (req_ch),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   mel_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .not_empty  (q_not_empty)
   );

   mel_back #(
      .LINE_MAX (LINE_MAX)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_head      (q_head),
      .q_not_empty (q_not_empty),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_res     (rsp_res)
   );

   // unpack the result record onto its ports
   assign rsp_status      = rsp_res.status;
   assign rsp_token_kind  = rsp_res.token_kind;
   assign rsp_start_pos   = rsp_res.start_pos;
   assign rsp_token_len   = rsp_res.token_len;
   assign rsp_op_char     = rsp_res.op_char;
   assign rsp_last_of_run = rsp_res.last_of_run;

endmodule : math_expression_lexer_core
`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for math_expression_lexer_core
// Feeds hand-written and random expression lines, predicts every token and
// error record and checks them in order against the block's output, with
// random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------

package lexer_tb_pkg;
   import mel_pkg::*;

   localparam int unsigned LINE_LIMIT = LINE_MAX_DEFAULT;
   localparam int unsigned ITEM_GOAL  = 950;

   localparam logic [7:0] CH_LPAREN = "(";
   localparam logic [7:0] CH_RPAREN = ")";
   localparam logic [7:0] CH_COMMA  = ",";
   localparam logic [7:0] CH_DOT    = ".";
   localparam logic [7:0] CH_UNDER  = "_";

   typedef enum logic [1:0] {
      LX_IDLE,
      LX_NUM,
      LX_NAME,
      LX_ERR
   } lex_state_type;

   function automatic bit is_oper(logic [7:0] c);
      return c == "+" || c == "-" || c == "*" || c == "/" || c == "^";
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   // space, tab, LF, VT, FF, CR and comma
   function automatic bit is_skipped(logic [7:0] c);
      return c == " " || (c >= 8'h09 && c <= 8'h0D) || c == CH_COMMA;
   endfunction

   class token_scoreboard;
      result_type    pending_tokens[$];
      lex_state_type state;
      int unsigned   pos;
      int unsigned   tok_start;
      bit            dot_seen;
      bit            under_seen;
      int unsigned   mismatches;
      int unsigned   results_checked;
      int unsigned   requests_seen;
      int unsigned   live_requests;
      int unsigned   lines_done;
      int unsigned   kind_hits[8];
      int unsigned   status_hits[4];

      function new();
         clear_line();
      endfunction

      function void clear_line();
         state      = LX_IDLE;
         pos        = 0;
         tok_start  = 0;
         dot_seen   = 1'b0;
         under_seen = 1'b0;
      endfunction

      function void push(status_type st, token_kind_type tk, int unsigned sp,
                         int unsigned len, logic [7:0] op);
         result_type r;
         r.status      = st;
         r.token_kind  = tk;
         r.start_pos   = START_W'(sp);
         r.token_len   = LEN_W'(len);
         r.op_char     = op;
         r.last_of_run = 1'b0;
         pending_tokens.insert(pending_tokens.size(), r);
      endfunction

      // emit whatever number or name is open, ending just before end_pos
      function void close_token(int unsigned end_pos);
         token_kind_type tk;
         if (state == LX_NUM) begin
            push(ST_TOKEN, TK_CONST, tok_start, end_pos - tok_start, 8'h00);
         end else if (state == LX_NAME) begin
            tk = dot_seen ? TK_VECTOR : (under_seen ? TK_MATRIX : TK_VAR);
            push(ST_TOKEN, tk, tok_start, end_pos - tok_start, 8'h00);
         end
      endfunction

      function void note_request(logic eol, logic [7:0] c);
         int unsigned queued;
         int unsigned p;
         bit          idle_pass;
         requests_seen++;
         queued    = pending_tokens.size();
         idle_pass = 1'b0;
         p         = 0;
         if (eol) begin
            close_token(pos);
            clear_line();
            lines_done++;
         end else if (state == LX_ERR) begin
            // dropped until end of line
         end else if (pos >= LINE_LIMIT) begin
            push(ST_TOO_LONG, TK_LPAREN, 0, 0, 8'h00);
            state = LX_ERR;
         end else begin
            live_requests++;
            p         = pos;
            pos       = p + 1;
            idle_pass = 1'b1;
            if (state == LX_NUM) begin
               if (is_digit(c)) begin
                  idle_pass = 1'b0;
               end else if (c == CH_DOT) begin
                  idle_pass = 1'b0;
                  if (dot_seen) begin
                     push(ST_MULTI_DOT, TK_LPAREN, p, 1, 8'h00);
                     state = LX_ERR;
                  end else begin
                     dot_seen = 1'b1;
                  end
               end else begin
                  close_token(p);
                  state = LX_IDLE;
               end
            end else if (state == LX_NAME) begin
               if (c == CH_LPAREN) begin
                  push(ST_TOKEN, TK_FUNC, tok_start, p - tok_start, 8'h00);
                  state = LX_IDLE;
               end else if (is_oper(c) || c == CH_COMMA || c == CH_RPAREN) begin
                  close_token(p);
                  state = LX_IDLE;
               end else begin
                  idle_pass = 1'b0;
                  if (c == CH_DOT) dot_seen = 1'b1;
                  if (c == CH_UNDER) under_seen = 1'b1;
               end
            end
         end

         if (idle_pass && !is_skipped(c)) begin
            if (c == CH_LPAREN) begin
               push(ST_TOKEN, TK_LPAREN, p, 1, 8'h00);
            end else if (c == CH_RPAREN) begin
               push(ST_TOKEN, TK_RPAREN, p, 1, 8'h00);
            end else if (is_oper(c)) begin
               push(ST_TOKEN, TK_OPER, p, 1, c);
            end else if (is_digit(c) || is_alpha(c)) begin
               state      = is_digit(c) ? LX_NUM : LX_NAME;
               tok_start  = p;
               dot_seen   = 1'b0;
               under_seen = 1'b0;
            end else begin
               push(ST_BAD_CHAR, TK_LPAREN, p, 1, 8'h00);
               state = LX_ERR;
            end
         end

         if (pending_tokens.size() > queued)
            pending_tokens[pending_tokens.size() - 1].last_of_run = 1'b1;
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("mismatch: %s", what);
      endtask

      task compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (want !== got)
            report_mismatch($sformatf("record %0d %s: expected %0d, got %0d",
                                      results_checked, name, want, got));
      endtask

      task check_token(result_type got);
         result_type want;
         results_checked++;
         status_hits[got.status]++;
         if (got.status == ST_TOKEN) kind_hits[got.token_kind]++;
         if (pending_tokens.size() == 0) begin
            report_mismatch($sformatf("record %0d not expected: status %0d kind %0d at %0d",
                                      results_checked, got.status, got.token_kind,
                                      got.start_pos));
         end else begin
            want = pending_tokens.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("token_kind", want.token_kind, got.token_kind);
            compare_field("start_pos", want.start_pos, got.start_pos);
            compare_field("token_len", want.token_len, got.token_len);
            compare_field("op_char", want.op_char, got.op_char);
            compare_field("last_of_run", want.last_of_run, got.last_of_run);
         end
      endtask
   endclass

endpackage : lexer_tb_pkg

module testbench;
   import mel_pkg::*;
   import lexer_tb_pkg::*;

   // ------------------------------------------------------------------
   // Block inputs start at known values; afterwards they change only by
   // nonblocking writes on the rising edge.
   // ------------------------------------------------------------------
   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_kind  = 1'b0;
   logic [CH_W-1:0]    req_ch    = '0;
   logic               rsp_stall = 1'b0;

   logic               req_stall;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic [2:0]         rsp_token_kind;
   logic [START_W-1:0] rsp_start_pos;
   logic [LEN_W-1:0]   rsp_token_len;
   logic [CH_W-1:0]    rsp_op_char;
   logic               rsp_last_of_run;

   token_scoreboard    board;

   // characters of the line being built, sent in order, then end of line
   logic [7:0]         line_buf[$];

   math_expression_lexer_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_ch          (req_ch),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_start_pos   (rsp_start_pos),
      .rsp_token_len   (rsp_token_len),
      .rsp_op_char     (rsp_op_char),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // 4 ns period, starting low so the first rising edge is at 2 ns
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // ------------------------------------------------------------------
   // Random delay lengths drawn from three ranges: mostly the shortest,
   // some from the middle range, a few long ones.
   // ------------------------------------------------------------------
   function automatic int unsigned gap_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // append one character to the line being built
   function automatic void add_char(logic [7:0] c);
      line_buf.insert(line_buf.size(), c);
   endfunction

   // ------------------------------------------------------------------
   // Character pickers for the line builder
   // ------------------------------------------------------------------
   function automatic logic [7:0] any_letter();
      logic [7:0] c;
      c = 8'("a" + $urandom_range(0, 25));
      if ($urandom_range(0, 1)) c = c - 8'h20;
      return c;
   endfunction

   function automatic logic [7:0] any_digit();
      return 8'("0" + $urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] pick_oper();
      case ($urandom_range(0, 4))
         0:       return "+";
         1:       return "-";
         2:       return "*";
         3:       return "/";
         default: return "^";
      endcase
   endfunction

   // anything a name swallows: letters, digits, dot, underscore, and any
   // other byte that is not an operator, comma or parenthesis
   function automatic logic [7:0] name_body_char();
      logic [7:0] c;
      case ($urandom_range(0, 9))
         0:       c = CH_DOT;
         1:       c = CH_UNDER;
         2: begin
            do c = 8'($urandom);
            while (is_oper(c) || c == CH_COMMA || c == CH_LPAREN || c == CH_RPAREN);
         end
         3, 4:    c = any_digit();
         default: c = any_letter();
      endcase
      return c;
   endfunction

   // a byte that no idle-mode rule accepts
   function automatic logic [7:0] bad_char();
      logic [7:0] c;
      do c = 8'($urandom);
      while (is_skipped(c) || c == CH_LPAREN || c == CH_RPAREN || is_oper(c) ||
             is_digit(c) || is_alpha(c));
      return c;
   endfunction

   function automatic void add_blank();
      case ($urandom_range(0, 3))
         0:       add_char(" ");
         1:       add_char(CH_COMMA);
         default: add_char(8'($urandom_range(9, 13)));
      endcase
   endfunction

   // digits with an optional fraction; twin_dots forces a second dot
   function automatic void add_number(bit twin_dots);
      repeat ($urandom_range(1, 4)) add_char(any_digit());
      if (twin_dots || $urandom_range(0, 2) == 0) begin
         add_char(CH_DOT);
         repeat ($urandom_range(0, 3)) add_char(any_digit());
      end
      if (twin_dots) begin
         add_char(CH_DOT);
         repeat ($urandom_range(0, 2)) add_char(any_digit());
      end
   endfunction

   // a name; a nonzero mark (dot or underscore) lands somewhere in the body
   function automatic void add_name(logic [7:0] mark);
      int unsigned body;
      int unsigned spot;
      body = $urandom_range(0, 5);
      add_char(any_letter());
      spot = line_buf.size() + $urandom_range(0, body);
      repeat (body) add_char(name_body_char());
      if (mark != 8'h00) line_buf.insert(spot, mark);
   endfunction

   // ------------------------------------------------------------------
   // Random line: mostly expressions with random operands, the rest
   // broken expressions, raw noise bytes and blank lines.
   // ------------------------------------------------------------------
   function automatic void build_line();
      int unsigned style;
      int unsigned operands;
      line_buf.delete();
      style = $urandom_range(0, 99);
      if (style < 10) begin
         repeat ($urandom_range(1, 12)) add_char(8'($urandom));
      end else if (style < 14) begin
         repeat ($urandom_range(0, 3)) add_blank();
      end else begin
         operands = $urandom_range(1, 8);
         for (int k = 0; k < operands; k++) begin
            if ($urandom_range(0, 3) == 0) add_blank();
            case ($urandom_range(0, 6))
               0, 1: add_number(1'b0);
               2:    add_name(8'h00);
               3:    add_name($urandom_range(0, 1) ? CH_DOT : CH_UNDER);
               4: begin
                  // function call
                  add_name(8'h00);
                  add_char(CH_LPAREN);
               end
               5:    add_char(CH_LPAREN);
               default: begin
                  add_number(1'b0);
                  add_name(8'h00);
               end
            endcase
            // separator; the last one is often left off so end of line closes
            if (k + 1 < operands || $urandom_range(0, 1)) begin
               case ($urandom_range(0, 9))
                  0:       add_char(CH_COMMA);
                  1, 2:    add_char(CH_RPAREN);
                  default: add_char(pick_oper());
               endcase
               if ($urandom_range(0, 4) == 0) add_blank();
            end
         end
         // broken lines: stray byte somewhere, or a number with two dots
         if (style >= 85) begin
            if ($urandom_range(0, 1)) begin
               line_buf.insert($urandom_range(0, line_buf.size()), bad_char());
            end else begin
               add_number(1'b1);
               add_name(8'h00);
            end
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // Request driver: valid and payload go up on an edge and are held
   // until an edge where the block is not stalling.
   // ------------------------------------------------------------------
   task automatic send_request(input logic eol, input logic [7:0] c);
      req_valid <= 1'b1;
      req_kind  <= eol;
      req_ch    <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // optional idle time after a request; steady lines send back to back
   task automatic pause_sender(input bit steady);
      if (!steady && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat (gap_length()) @(posedge clock);
      end
   endtask

   task automatic send_line(input bit steady);
      foreach (line_buf[i]) begin
         send_request(1'b0, line_buf[i]);
         pause_sender(steady);
      end
      // the character byte is don't-care on end of line; keep it random
      send_request(1'b1, 8'($urandom));
      pause_sender(steady);
   endtask

   task automatic send_text(input string text);
      line_buf.delete();
      for (int i = 0; i < text.len(); i++) add_char(text[i]);
      send_line($urandom_range(0, 1));
   endtask

   // hold the sender off until every predicted record has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending_tokens.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Result side back-pressure: free stretches (some long) alternating
   // with stalls of random length.
   // ------------------------------------------------------------------
   initial begin : result_backpressure
      int unsigned free_run;
      forever begin
         free_run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 6);
         repeat (free_run) @(posedge clock);
         rsp_stall <= 1'b1;
         repeat (gap_length()) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Observer: both handshakes are sampled at the rising edge, before the
   // edge's own updates land. Requests are noted first so a record can
   // never be checked ahead of the request that caused it.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : observe
      result_type seen;
      if (!reset) begin
         if (req_valid && !req_stall) board.note_request(req_kind, req_ch);
         if (rsp_valid && !rsp_stall) begin
            seen.status      = status_type'(rsp_status);
            seen.token_kind  = token_kind_type'(rsp_token_kind);
            seen.start_pos   = rsp_start_pos;
            seen.token_len   = rsp_token_len;
            seen.op_char     = rsp_op_char;
            seen.last_of_run = rsp_last_of_run;
            board.check_token(seen);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Hand-written lines:
      //  - call closed by '(', matrix name closed by ')', minus, a fraction cut by
      //    caret (two records from one request), vector name flushed at end of line
      //  - second dot in a number, then a letter that must be dropped
      //  - tab skipped, number cut by an unknown byte (constant plus error)
      //  - plain variables with the remaining operators, operator at line end
      send_text("g(u_2)-5.1^w.z");
      send_text("3..y");
      send_text("\t9@");
      send_text("x+y*z/");
      wait_for_drain();

      // Random lines until the request budget is used up
      while (board.requests_seen < ITEM_GOAL) begin
         build_line();
         send_line($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 24) == 0) wait_for_drain();
      end

      // drain, then give the pipeline time to show any stray record
      wait_for_drain();
      repeat (20) @(posedge clock);

      $display("Lexed %0d lines from %0d requests (%0d live characters); %0d records, %0d mismatches.",
               board.lines_done, board.requests_seen, board.live_requests,
               board.results_checked, board.mismatches);
      $display("Kinds lp %0d rp %0d op %0d num %0d call %0d vec %0d mat %0d var %0d;",
               board.kind_hits[0], board.kind_hits[1], board.kind_hits[2],
               board.kind_hits[3], board.kind_hits[4], board.kind_hits[5],
               board.kind_hits[6], board.kind_hits[7]);
      $display("errors: bad char %0d, double dot %0d, too long %0d",
               board.status_hits[1], board.status_hits[2], board.status_hits[3]);
      if (board.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin : watchdog
      #6_000_000;
      $display("Timeout: %0d records still expected.", board.pending_tokens.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule : testbench
